>>> src/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and codes for the three-level priority ticket queue.
// ----------------------------------------------------------------------------
package tpq_pkg;

    localparam int PRIO_W = 2;
    localparam int TAG_W  = 8;
    localparam int TKO_W  = 16;
    localparam int OCC_W  = 5;
    localparam int STAT_W = 2;

    localparam logic [PRIO_W-1:0] TOP_PRIORITY = 2'd2;

    localparam logic KIND_ADD = 1'b0;

    localparam logic [STAT_W-1:0] ST_ADDED    = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECTED = 2'd1;
    localparam logic [STAT_W-1:0] ST_SERVED   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CALL,
        S_WALK,
        S_PUT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        RES_EMPTY,
        RES_REJECT,
        RES_ADDED,
        RES_SERVED
    } t_res_sel;

    typedef struct packed {
        logic     load_item;
        logic     tk_commit;
        logic     idx_load_count;
        logic     idx_load_one;
        logic     idx_dec;
        logic     rd_en;
        logic     wr_new;
        logic     wr_shift;
        logic     res_load;
        t_res_sel res_sel;
        logic     commit_add;
        logic     commit_call;
        logic     push;
    } t_dp_cmd;

    typedef struct packed {
        logic is_add;
        logic full;
        logic empty;
        logic stop;
        logic idx_is_one;
        logic out_free;
    } t_dp_sts;

endpackage

>>> src/tpq_ram.sv
// ----------------------------------------------------------------------------
// tpq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/tpq_ctrl.sv
// ----------------------------------------------------------------------------
// tpq_ctrl
// Sequencer: decodes a beat, walks the table on insert, hands off result.
// ----------------------------------------------------------------------------
module tpq_ctrl
    import tpq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_add) begin
                    if (i_sts.full) begin
                        o_cmd.res_sel  = RES_REJECT;
                        o_cmd.res_load = 1'b1;
                        n_state        = S_OUT;
                    end else begin
                        o_cmd.tk_commit      = 1'b1;
                        o_cmd.idx_load_count = 1'b1;
                        if (i_sts.empty) begin
                            n_state = S_PUT;
                        end else begin
                            o_cmd.rd_en = 1'b1;
                            n_state     = S_WALK;
                        end
                    end
                end else if (i_sts.empty) begin
                    o_cmd.res_sel  = RES_EMPTY;
                    o_cmd.res_load = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.idx_load_one = 1'b1;
                    o_cmd.rd_en        = 1'b1;
                    n_state            = S_CALL;
                end
            end
            S_CALL: begin
                o_cmd.res_sel     = RES_SERVED;
                o_cmd.res_load    = 1'b1;
                o_cmd.commit_call = 1'b1;
                n_state           = S_OUT;
            end
            S_WALK: begin
                if (i_sts.stop) begin
                    o_cmd.wr_new     = 1'b1;
                    o_cmd.commit_add = 1'b1;
                    o_cmd.res_sel    = RES_ADDED;
                    o_cmd.res_load   = 1'b1;
                    n_state          = S_OUT;
                end else begin
                    o_cmd.wr_shift = 1'b1;
                    o_cmd.idx_dec  = 1'b1;
                    if (i_sts.idx_is_one) begin
                        n_state = S_PUT;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                    end
                end
            end
            S_PUT: begin
                o_cmd.wr_new     = 1'b1;
                o_cmd.commit_add = 1'b1;
                o_cmd.res_sel    = RES_ADDED;
                o_cmd.res_load   = 1'b1;
                n_state          = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/tpq_dp.sv
// ----------------------------------------------------------------------------
// tpq_dp
// Datapath: circular entry table, ticket counter, result and output regs.
// ----------------------------------------------------------------------------
module tpq_dp
    import tpq_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int TICKET_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic              i_kind,
    input  logic [PRIO_W-1:0] i_priority_req,
    input  logic [TAG_W-1:0]  i_client_tag,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [STAT_W-1:0] o_status,
    output logic [TKO_W-1:0]  o_ticket,
    output logic [PRIO_W-1:0] o_out_priority,
    output logic [TAG_W-1:0]  o_out_tag,
    output logic [OCC_W-1:0]  o_occupancy
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = PRIO_W + TICKET_BITS + TAG_W;
    localparam logic [AW:0] CAP_EXT = (AW + 1)'(CAPACITY);

    logic                   r_kind;
    logic [PRIO_W-1:0]      r_prio;
    logic [TAG_W-1:0]       r_tag;
    logic [TICKET_BITS-1:0] r_tk;
    logic [TICKET_BITS-1:0] r_last;
    logic [CW-1:0]          r_count;
    logic [AW-1:0]          r_head;
    logic [AW-1:0]          r_idx;
    logic [AW-1:0]          n_idx;

    logic [STAT_W-1:0]      r_res_status;
    logic [TKO_W-1:0]       r_res_ticket;
    logic [PRIO_W-1:0]      r_res_prio;
    logic [TAG_W-1:0]       r_res_tag;
    logic [OCC_W-1:0]       r_res_occ;

    logic                   r_out_valid;
    logic [STAT_W-1:0]      r_out_status;
    logic [TKO_W-1:0]       r_out_ticket;
    logic [PRIO_W-1:0]      r_out_prio;
    logic [TAG_W-1:0]       r_out_tag;
    logic [OCC_W-1:0]       r_out_occ;

    logic [AW-1:0]          rd_log;
    logic [AW:0]            rd_sum;
    logic [AW:0]            wr_sum;
    logic [AW:0]            head_inc;
    logic [AW-1:0]          rd_addr;
    logic [AW-1:0]          wr_addr;
    logic [DW-1:0]          wr_data;
    logic [DW-1:0]          rd_data;
    logic [PRIO_W-1:0]      rd_prio;
    logic [TICKET_BITS-1:0] rd_tk;
    logic [TAG_W-1:0]       rd_tag;

    assign rd_prio = rd_data[DW-1 -: PRIO_W];
    assign rd_tk   = rd_data[TAG_W +: TICKET_BITS];
    assign rd_tag  = rd_data[TAG_W-1:0];

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.idx_load_count) begin
            n_idx = r_count[AW-1:0];
        end else if (i_cmd.idx_load_one) begin
            n_idx = AW'(1);
        end else if (i_cmd.idx_dec) begin
            n_idx = r_idx - AW'(1);
        end
    end

    // logical position -> physical slot, wrapping at capacity
    always_comb begin
        rd_log   = n_idx - AW'(1);
        rd_sum   = {1'b0, r_head} + {1'b0, rd_log};
        wr_sum   = {1'b0, r_head} + {1'b0, r_idx};
        head_inc = {1'b0, r_head} + (AW + 1)'(1);
        rd_addr  = (rd_sum >= CAP_EXT) ? AW'(rd_sum - CAP_EXT) : rd_sum[AW-1:0];
        wr_addr  = (wr_sum >= CAP_EXT) ? AW'(wr_sum - CAP_EXT) : wr_sum[AW-1:0];
        wr_data  = i_cmd.wr_new ? {r_prio, r_tk, r_tag} : rd_data;
    end

    tpq_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_new | i_cmd.wr_shift),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (i_cmd.rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.tk_commit) begin
                r_last <= r_last + TICKET_BITS'(1);
            end
            if (i_cmd.commit_add) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.commit_call) begin
                r_count <= r_count - CW'(1);
                r_head  <= (head_inc >= CAP_EXT) ? '0 : head_inc[AW-1:0];
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load_item) begin
            r_kind <= i_kind;
            r_prio <= (i_priority_req > TOP_PRIORITY) ? TOP_PRIORITY : i_priority_req;
            r_tag  <= i_client_tag;
        end
        if (i_cmd.tk_commit) begin
            r_tk <= r_last + TICKET_BITS'(1);
        end
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                RES_EMPTY: begin
                    r_res_status <= ST_EMPTY;
                    r_res_ticket <= '0;
                    r_res_prio   <= '0;
                    r_res_tag    <= '0;
                    r_res_occ    <= '0;
                end
                RES_REJECT: begin
                    r_res_status <= ST_REJECTED;
                    r_res_ticket <= '0;
                    r_res_prio   <= r_prio;
                    r_res_tag    <= r_tag;
                    r_res_occ    <= OCC_W'(r_count);
                end
                RES_ADDED: begin
                    r_res_status <= ST_ADDED;
                    r_res_ticket <= TKO_W'(r_tk);
                    r_res_prio   <= r_prio;
                    r_res_tag    <= r_tag;
                    r_res_occ    <= OCC_W'(r_count + CW'(1));
                end
                RES_SERVED: begin
                    r_res_status <= ST_SERVED;
                    r_res_ticket <= TKO_W'(rd_tk);
                    r_res_prio   <= rd_prio;
                    r_res_tag    <= rd_tag;
                    r_res_occ    <= OCC_W'(r_count - CW'(1));
                end
                default: begin
                    r_res_status <= ST_EMPTY;
                    r_res_ticket <= '0;
                    r_res_prio   <= '0;
                    r_res_tag    <= '0;
                    r_res_occ    <= '0;
                end
            endcase
        end
        if (i_cmd.push) begin
            r_out_status <= r_res_status;
            r_out_ticket <= r_res_ticket;
            r_out_prio   <= r_res_prio;
            r_out_tag    <= r_res_tag;
            r_out_occ    <= r_res_occ;
        end
    end

    always_comb begin
        o_sts.is_add     = (r_kind == KIND_ADD);
        o_sts.full       = (r_count == CW'(CAPACITY));
        o_sts.empty      = (r_count == '0);
        o_sts.stop       = (rd_prio >= r_prio);
        o_sts.idx_is_one = (r_idx == AW'(1));
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_ticket       = r_out_ticket;
    assign o_out_priority = r_out_prio;
    assign o_out_tag      = r_out_tag;
    assign o_occupancy    = r_out_occ;

endmodule

>>> src/three_level_priority_ticket_queue.sv
// ----------------------------------------------------------------------------
// three_level_priority_ticket_queue
// Bounded three-level priority queue, FIFO within a level, ticket stamping.
//
//   channel   direction  handshake          payload
//   request   in         i_valid/o_ready    i_kind i_priority_req i_client_tag
//   result    out        o_valid/i_ready    o_status o_ticket o_out_priority
//                                           o_out_tag o_occupancy
//
// A reject or a call on an empty table loads its result in the decode state; a call
// that serves reads the head entry and loads it in the call state. An add shifts the
// lower-priority entries that the insert walk passes, one per cycle through the table
// RAM (up to CAPACITY-1), then writes the new entry. The table is circular, so a call
// never shifts. Ready returns once the result has moved into the output register.
// Reset empties the queue and zeroes the ticket counter; no clearing pass.
// A stalled result holds; the next request is taken while it waits.
// ----------------------------------------------------------------------------
module three_level_priority_ticket_queue
    import tpq_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int TICKET_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic [PRIO_W-1:0] i_priority_req,
    input  logic [TAG_W-1:0]  i_client_tag,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [TKO_W-1:0]  o_ticket,
    output logic [PRIO_W-1:0] o_out_priority,
    output logic [TAG_W-1:0]  o_out_tag,
    output logic [OCC_W-1:0]  o_occupancy
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    tpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tpq_dp #(
        .CAPACITY    (CAPACITY),
        .TICKET_BITS (TICKET_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_priority_req (i_priority_req),
        .i_client_tag   (i_client_tag),
        .i_out_ready    (i_ready),
        .o_out_valid    (o_valid),
        .o_status       (o_status),
        .o_ticket       (o_ticket),
        .o_out_priority (o_out_priority),
        .o_out_tag      (o_out_tag),
        .o_occupancy    (o_occupancy)
    );

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the three-level priority ticket queue. A short table of
// directed beats (empty call, saturated priority, full table, rejects) runs
// first. Random add/call traffic follows, with the add rate shifting so the
// table fills and drains. The table is then emptied and a run of add/call
// pairs follows. Every result beat is checked against a local model of
// the sorted table, under changing sender and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tpq_pkg::*;

    localparam int   CAPACITY    = 16;
    localparam int   TICKET_BITS = 16;
    localparam int   CYCLE_LIMIT = 4_000_000;
    localparam int   TAIL_CYCLES = 40;
    localparam logic KIND_CALL   = ~KIND_ADD;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TKO_W-1:0]  ticket;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
        logic [OCC_W-1:0]  occ;
    } t_beat;

    typedef struct packed {
        logic              kind;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
        logic              has_want;
        t_beat             want;
    } t_row;

    localparam t_beat NO_WANT = '0;
    localparam int    DIR_N   = 24;

    localparam t_row DIR_ROWS [0:DIR_N-1] = '{
        '{KIND_CALL, 2'd0, 8'h00, 1'b1, '{ST_EMPTY, 16'd0, 2'd0, 8'h00, 5'd0}},
        '{KIND_ADD,  2'd0, 8'h00, 1'b1, '{ST_ADDED, 16'd1, 2'd0, 8'h00, 5'd1}},
        '{KIND_ADD,  2'd3, 8'hFF, 1'b1, '{ST_ADDED, 16'd2, TOP_PRIORITY, 8'hFF, 5'd2}},
        '{KIND_ADD,  2'd1, 8'h5A, 1'b0, NO_WANT},
        '{KIND_ADD,  2'd2, 8'hA5, 1'b0, NO_WANT},
        '{KIND_CALL, 2'd3, 8'hFF, 1'b0, NO_WANT},
        '{KIND_ADD,  2'd0, 8'h01, 1'b0, NO_WANT},
        '{KIND_ADD,  2'd2, 8'h02, 1'b0, NO_WANT},
        '{KIND_ADD,  2'd1, 8'h04, 1'b0, NO_WANT},
        '{KIND_ADD,  2'd0, 8'h08, 1'b0, NO_WANT},
        '{KIND_ADD,  2'd3, 8'h10, 1'b0, NO_WANT},
        '{KIND_ADD,  2'd1, 8'h20, 1'b0, NO_WANT},
        '{KIND_ADD,  2'd2, 8'h40, 1'b0, NO_WANT},
        '{KIND_ADD,  2'd0, 8'h80, 1'b0, NO_WANT},
        '{KIND_ADD,  2'd1, 8'hFE, 1'b0, NO_WANT},
        '{KIND_ADD,  2'd2, 8'hFD, 1'b0, NO_WANT},
        '{KIND_ADD,  2'd0, 8'hFB, 1'b0, NO_WANT},
        '{KIND_ADD,  2'd3, 8'hF7, 1'b0, NO_WANT},
        '{KIND_ADD,  2'd1, 8'hEF, 1'b0, NO_WANT},
        '{KIND_ADD,  2'd3, 8'h77, 1'b1, '{ST_REJECTED, 16'd0, TOP_PRIORITY, 8'h77, 5'd16}},
        '{KIND_ADD,  2'd0, 8'h00, 1'b1, '{ST_REJECTED, 16'd0, 2'd0, 8'h00, 5'd16}},
        '{KIND_CALL, 2'd0, 8'h00, 1'b0, NO_WANT},
        '{KIND_CALL, 2'd1, 8'h3C, 1'b0, NO_WANT},
        '{KIND_CALL, 2'd2, 8'hC3, 1'b0, NO_WANT}
    };

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              i_kind         = KIND_ADD;
    logic [PRIO_W-1:0] i_priority_req = '0;
    logic [TAG_W-1:0]  i_client_tag   = '0;
    logic              i_ready        = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [STAT_W-1:0] o_status;
    logic [TKO_W-1:0]  o_ticket;
    logic [PRIO_W-1:0] o_out_priority;
    logic [TAG_W-1:0]  o_out_tag;
    logic [OCC_W-1:0]  o_occupancy;

    // directed expectation riding with the current request beat
    logic  cur_has_want = 1'b0;
    t_beat cur_want     = '0;

    t_beat       pending_q [$];
    int          mismatches    = 0;
    int unsigned cycle_cnt     = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    // model of the sorted table
    logic [PRIO_W-1:0] tbl_prio   [CAPACITY];
    logic [TKO_W-1:0]  tbl_ticket [CAPACITY];
    logic [TAG_W-1:0]  tbl_tag    [CAPACITY];
    int                tbl_count      = 0;
    logic [TICKET_BITS-1:0] ticket_ctr = '0;

    three_level_priority_ticket_queue #(
        .CAPACITY    (CAPACITY),
        .TICKET_BITS (TICKET_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_priority_req (i_priority_req),
        .i_client_tag   (i_client_tag),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_ticket       (o_ticket),
        .o_out_priority (o_out_priority),
        .o_out_tag      (o_out_tag),
        .o_occupancy    (o_occupancy)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_beat queue_step(input logic kind, input logic [PRIO_W-1:0] prio_in,
                                         input logic [TAG_W-1:0] tag);
        t_beat             r;
        logic [PRIO_W-1:0] p;
        int                pos;
        int                i;
        r = '0;
        p = (prio_in > TOP_PRIORITY) ? TOP_PRIORITY : prio_in;
        if (kind == KIND_ADD) begin
            if (tbl_count >= CAPACITY) begin
                r.status = ST_REJECTED;
                r.prio   = p;
                r.tag    = tag;
                r.occ    = OCC_W'(tbl_count);
            end else begin
                ticket_ctr = ticket_ctr + TICKET_BITS'(1);
                pos = 0;
                while (pos < tbl_count && tbl_prio[pos] >= p) begin
                    pos++;
                end
                for (i = tbl_count; i > pos; i--) begin
                    tbl_prio[i]   = tbl_prio[i-1];
                    tbl_ticket[i] = tbl_ticket[i-1];
                    tbl_tag[i]    = tbl_tag[i-1];
                end
                tbl_prio[pos]   = p;
                tbl_ticket[pos] = TKO_W'(ticket_ctr);
                tbl_tag[pos]    = tag;
                tbl_count++;
                r.status = ST_ADDED;
                r.ticket = TKO_W'(ticket_ctr);
                r.prio   = p;
                r.tag    = tag;
                r.occ    = OCC_W'(tbl_count);
            end
        end else if (tbl_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.status = ST_SERVED;
            r.ticket = tbl_ticket[0];
            r.prio   = tbl_prio[0];
            r.tag    = tbl_tag[0];
            for (i = 1; i < tbl_count; i++) begin
                tbl_prio[i-1]   = tbl_prio[i];
                tbl_ticket[i-1] = tbl_ticket[i];
                tbl_tag[i-1]    = tbl_tag[i];
            end
            tbl_count--;
            r.occ = OCC_W'(tbl_count);
        end
        return r;
    endfunction

    // acceptance and result check, both sampled at the rising edge
    always @(posedge i_clk) begin : monitor
        t_beat got;
        t_beat want;
        t_beat model;
        got = '{o_status, o_ticket, o_out_priority, o_out_tag, o_occupancy};
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result beat at cycle %0d:", cycle_cnt);
                    $display("    got st=%0d tk=%0d pr=%0d tag=%0d occ=%0d",
                             got.status, got.ticket, got.prio, got.tag, got.occ);
                end
            end else begin
                want = pending_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at cycle %0d: expected st=%0d tk=%0d pr=%0d tag=%0d occ=%0d",
                                 cycle_cnt, want.status, want.ticket, want.prio, want.tag,
                                 want.occ);
                        $display("    got st=%0d tk=%0d pr=%0d tag=%0d occ=%0d",
                                 got.status, got.ticket, got.prio, got.tag, got.occ);
                    end
                end
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            model = queue_step(i_kind, i_priority_req, i_client_tag);
            pending_q.insert(pending_q.size(), cur_has_want ? cur_want : model);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("three_level_priority_ticket_queue test failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // entered just after a falling edge, returns at the falling edge after the beat
    task automatic send_beat(input logic kind, input logic [PRIO_W-1:0] prio,
                             input logic [TAG_W-1:0] tag, input logic has_want,
                             input t_beat want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_kind         <= kind;
        i_priority_req <= prio;
        i_client_tag   <= tag;
        cur_has_want   <= has_want;
        cur_want       <= want;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic random_run(input int n);
        int                add_pct;
        logic              kind;
        logic [PRIO_W-1:0] p;
        add_pct = 50;
        for (int j = 0; j < n; j++) begin
            if (j % 40 == 0) begin
                case ($urandom_range(3))
                    0:       add_pct = 15;
                    1:       add_pct = 50;
                    2:       add_pct = 85;
                    default: add_pct = 97;
                endcase
            end
            kind = ($urandom_range(99) < add_pct) ? KIND_ADD : KIND_CALL;
            if ($urandom_range(7) == 0) begin
                p = '1;
            end else begin
                p = PRIO_W'($urandom_range(TOP_PRIORITY));
            end
            send_beat(kind, p, TAG_W'($urandom), 1'b0, NO_WANT);
        end
    endtask

    // called right after send_beat returns, so valid is lowered once
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    initial begin
        send_idle_pct = 22;
        recv_idle_pct = 60;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIR_ROWS[k]) begin
            send_beat(DIR_ROWS[k].kind, DIR_ROWS[k].prio, DIR_ROWS[k].tag,
                      DIR_ROWS[k].has_want, DIR_ROWS[k].want);
        end
        random_run(600);
        drain();

        send_idle_pct = 60;
        recv_idle_pct = 22;
        random_run(600);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_run(300);

        // empty the table, then a run of add/call pairs
        repeat (CAPACITY) send_beat(KIND_CALL, '0, '0, 1'b0, NO_WANT);
        repeat (16) begin
            send_beat(KIND_ADD, PRIO_W'($urandom_range(3)), TAG_W'($urandom), 1'b0, NO_WANT);
            send_beat(KIND_CALL, '0, '0, 1'b0, NO_WANT);
        end

        random_run(300);
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("three_level_priority_ticket_queue test passed");
        end else begin
            $display("three_level_priority_ticket_queue test failed");
        end
        $finish;
    end

endmodule

>>> sim.f
src/tpq_pkg.sv
src/tpq_ram.sv
src/tpq_ctrl.sv
src/tpq_dp.sv
src/three_level_priority_ticket_queue.sv
verif/tb_top.sv
